@@ src/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; define ASSERT_OFF to compile them out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`define ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

@@ src/spq_pkg.sv @@
// ---------------------------------------------------------------------------
// Sorted priority queue package
// Command and result types, cell control types and operation codes.
// ---------------------------------------------------------------------------
package spq_pkg;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_code_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  key;
    logic [15:0] entry_tag;
  } spq_cmd_t;

  typedef struct packed {
    logic        removed_valid;
    logic [7:0]  removed_key;
    logic [15:0] removed_tag;
    logic [1:0]  error_code;
    logic [4:0]  occupancy;
    logic [7:0]  front_key;
    logic [15:0] front_tag;
  } spq_result_t;

  typedef struct packed {
    logic [7:0]  key;
    logic [15:0] tag;
  } spq_entry_t;

  // Broadcast to every cell of the chain
  typedef struct packed {
    logic        ins;
    logic        rem;
    spq_entry_t  item;
  } spq_ctrl_t;

endpackage

@@ src/spq_cell.sv @@
// ---------------------------------------------------------------------------
// Sorted queue cell
// One slot of the sorted chain: holds an entry and, on an operation, keeps it or
// takes its upper neighbor's entry, the new entry or its lower neighbor's entry.
// ---------------------------------------------------------------------------
module spq_cell (
  input  logic               clk,
  input  spq_pkg::spq_ctrl_t ctrl,
  input  logic               occupied,
  input  spq_pkg::spq_entry_t prev_entry,
  input  logic               prev_place,
  input  spq_pkg::spq_entry_t next_entry,
  output spq_pkg::spq_entry_t entry,
  output spq_pkg::spq_entry_t entry_next,
  output logic               place
);
  import spq_pkg::*;

  // New entry belongs at or above this slot
  assign place = !occupied || (entry.key > ctrl.item.key);

  always_comb begin
    entry_next = entry;
    if (ctrl.ins) begin
      if (prev_place) begin
        entry_next = prev_entry;
      end else if (place) begin
        entry_next = ctrl.item;
      end
    end else if (ctrl.rem) begin
      entry_next = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

@@ src/sorted_priority_queue_unit.sv @@
// ---------------------------------------------------------------------------
// Sorted priority queue unit
// Bounded queue of keyed entries kept in ascending key order in a cell chain.
// ---------------------------------------------------------------------------
// Usage:
//   Drive cmd and raise start; the command transfers at the clock edge where
//   start is high and busy is low. busy stays low, so a command may transfer
//   in every cycle. kind selects insert (sorted, after equal keys) or remove
//   (smallest key leaves first).
//   The result appears on result in the cycle after the transfer, marked by done
//   for exactly one cycle; throughput 1 command per cycle.
//   Every cell compares its key with the broadcast key and shifts toward its
//   neighbor in the same cycle.
//   The result reports the removed entry, an error code (insert on a full
//   queue is dropped, remove on an empty queue does nothing), the occupancy
//   and the front entry after the operation.
//   The receiver cannot hold results off; each must be taken when done is high.
//   Reset empties the queue and clears done; stored entries are not cleared.
// ---------------------------------------------------------------------------
module sorted_priority_queue_unit #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  spq_pkg::spq_cmd_t    cmd,
  output logic                 busy,
  output logic                 done,
  output spq_pkg::spq_result_t result
);
  import spq_pkg::*;
  `include "assert_macros.svh"

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             accept;
  logic             full;
  logic             empty;
  spq_ctrl_t        ctrl;
  spq_result_t      result_next;

  spq_entry_t entry      [QUEUE_DEPTH];
  spq_entry_t entry_next [QUEUE_DEPTH];
  spq_entry_t prev_entry [QUEUE_DEPTH];
  spq_entry_t next_entry [QUEUE_DEPTH];
  logic       place      [QUEUE_DEPTH];
  logic       prev_place [QUEUE_DEPTH];
  logic       occupied   [QUEUE_DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count == CNT_W'(QUEUE_DEPTH));
  assign empty  = (count == '0);

  assign ctrl.ins       = accept && (cmd.kind == KIND_INSERT) && !full;
  assign ctrl.rem       = accept && (cmd.kind == KIND_REMOVE) && !empty;
  assign ctrl.item.key  = cmd.key;
  assign ctrl.item.tag  = cmd.entry_tag;

  // Neighbor wiring; the first cell sees an empty upper neighbor, the last cell its own entry below
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      occupied[i] = (CNT_W'(i) < count);
      if (i == 0) begin
        prev_entry[i] = '0;
        prev_place[i] = 1'b0;
      end else begin
        prev_entry[i] = entry[i-1];
        prev_place[i] = place[i-1];
      end
      if (i == QUEUE_DEPTH - 1) begin
        next_entry[i] = entry[i];
      end else begin
        next_entry[i] = entry[i+1];
      end
    end
  end

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    spq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (occupied[g]),
      .prev_entry (prev_entry[g]),
      .prev_place (prev_place[g]),
      .next_entry (next_entry[g]),
      .entry      (entry[g]),
      .entry_next (entry_next[g]),
      .place      (place[g])
    );
  end

  always_comb begin
    count_next = count;
    if (ctrl.ins) begin
      count_next = count + CNT_W'(1);
    end else if (ctrl.rem) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_comb begin
    result_next = '0;
    result_next.removed_valid = ctrl.rem;
    if (ctrl.rem) begin
      result_next.removed_key = entry[0].key;
      result_next.removed_tag = entry[0].tag;
    end
    if (cmd.kind == KIND_INSERT && full) begin
      result_next.error_code = ERR_FULL;
    end else if (cmd.kind == KIND_REMOVE && empty) begin
      result_next.error_code = ERR_EMPTY;
    end else begin
      result_next.error_code = ERR_OK;
    end
    result_next.occupancy = 5'(count_next);
    if (count_next != '0) begin
      result_next.front_key = entry_next[0].key;
      result_next.front_tag = entry_next[0].tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  `ASSERT_NEVER(a_count_bound, clk, rst, count > CNT_W'(QUEUE_DEPTH))
  `ASSERT_NEXT(a_done_follows, clk, rst, accept, done)
  `ASSERT_IMPLY(a_full_occ, clk, rst, done && result.error_code == ERR_FULL,
                result.occupancy == 5'(QUEUE_DEPTH) && !result.removed_valid)
  `ASSERT_IMPLY(a_removed_sorted, clk, rst,
                done && result.removed_valid && result.occupancy != 5'd0,
                result.removed_key <= result.front_key)
  `ASSERT_IMPLY(a_empty_front, clk, rst, done && result.error_code == ERR_EMPTY,
                result.occupancy == 5'd0 && result.front_key == 8'd0)

endmodule

@@ dv/sorted_priority_queue_unit_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sorted priority queue unit testbench
// Sends insert and remove commands with random gaps and keeps its own sorted
// array copy of the queue. Every result is checked field by field against
// that copy, in transfer order.
// ---------------------------------------------------------------------------
module sorted_priority_queue_unit_test;
  import spq_pkg::*;

  localparam int DEPTH         = 16;
  localparam int CLK_HALF      = 6;
  localparam int TARGET_ITEMS  = 450;
  localparam int TIMEOUT_TICKS = 100_000;

  typedef struct {
    spq_cmd_t    cmd;
    int unsigned gap;
    bit          settle;  // hold until every result is back
  } cmd_slot_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  spq_cmd_t    cmd = '0;
  logic        busy;
  logic        done;
  spq_result_t result;

  cmd_slot_t   cmd_backlog[$];
  spq_result_t status_due[$];

  logic [7:0]  held_keys[DEPTH];
  logic [15:0] held_tags[DEPTH];
  int unsigned held_count = 0;
  int unsigned gap_left = 0;
  int unsigned fail_count = 0;
  int unsigned queued_items = 0;

  sorted_priority_queue_unit #(
    .QUEUE_DEPTH(DEPTH)
  ) u_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done),
    .result(result)
  );

  always #CLK_HALF clk = ~clk;

  // Sorted insert after equal keys, remove from the front
  function automatic spq_result_t apply_queue_op(spq_cmd_t c);
    spq_result_t r;
    int unsigned pos;
    int i;
    r = '0;
    if (c.kind == KIND_INSERT) begin
      if (held_count >= DEPTH) begin
        r.error_code = ERR_FULL;
      end else begin
        pos = 0;
        while (pos < held_count && held_keys[pos] <= c.key) pos++;
        for (i = held_count; i > pos; i--) begin
          held_keys[i] = held_keys[i-1];
          held_tags[i] = held_tags[i-1];
        end
        held_keys[pos] = c.key;
        held_tags[pos] = c.entry_tag;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        r.error_code = ERR_EMPTY;
      end else begin
        r.removed_valid = 1'b1;
        r.removed_key   = held_keys[0];
        r.removed_tag   = held_tags[0];
        for (i = 1; i < held_count; i++) begin
          held_keys[i-1] = held_keys[i];
          held_tags[i-1] = held_tags[i];
        end
        held_count--;
      end
    end
    r.occupancy = 5'(held_count);
    if (held_count > 0) begin
      r.front_key = held_keys[0];
      r.front_tag = held_tags[0];
    end
    return r;
  endfunction

  function automatic spq_cmd_t idle_noise();
    spq_cmd_t c;
    c.kind      = 1'($urandom);
    c.key       = 8'($urandom);
    c.entry_tag = 16'($urandom);
    return c;
  endfunction

  task automatic add_cmd(logic kind, logic [7:0] key, logic [15:0] tag,
                         int unsigned gap, bit settle);
    cmd_slot_t s;
    s.cmd.kind      = kind;
    s.cmd.key       = key;
    s.cmd.entry_tag = tag;
    s.gap           = gap;
    s.settle        = settle;
    cmd_backlog.push_back(s);
    queued_items++;
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Driver: hold a command until it transfers, then wait out its gap
  always @(posedge clk) begin
    if (rst) begin
      start    <= 1'b0;
      cmd      <= '0;
      gap_left <= 0;
    end else begin
      if (start && !busy) status_due.push_back(apply_queue_op(cmd));
      if (!(start && busy)) begin
        if (gap_left != 0) begin
          start    <= 1'b0;
          cmd      <= idle_noise();
          gap_left <= gap_left - 1;
        end else if (cmd_backlog.size() != 0 &&
                     !(cmd_backlog[0].settle && status_due.size() != 0)) begin
          start    <= 1'b1;
          cmd      <= cmd_backlog[0].cmd;
          gap_left <= cmd_backlog[0].gap;
          void'(cmd_backlog.pop_front());
        end else begin
          start <= 1'b0;
          cmd   <= idle_noise();
        end
      end
    end
  end

  // Monitor: every done pulse consumes the oldest expected status
  always @(posedge clk) begin
    spq_result_t want;
    if (!rst && done) begin
      if (status_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, result);
        fail_count++;
      end else begin
        want = status_due.pop_front();
        check_field("removed_valid", 16'(want.removed_valid), 16'(result.removed_valid));
        check_field("removed_key", 16'(want.removed_key), 16'(result.removed_key));
        check_field("removed_tag", want.removed_tag, result.removed_tag);
        check_field("error_code", 16'(want.error_code), 16'(result.error_code));
        check_field("occupancy", 16'(want.occupancy), 16'(result.occupancy));
        check_field("front_key", 16'(want.front_key), 16'(result.front_key));
        check_field("front_tag", want.front_tag, result.front_tag);
      end
    end
  end

  initial begin
    int unsigned phase;
    int unsigned phase_len;
    int unsigned ins_pct;
    int unsigned n;
    bit          quiet;
    bit          tie_keys;
    logic [7:0]  key;

    // Remove on empty, extreme keys and tags, ties at both ends
    add_cmd(KIND_REMOVE, 8'hff, 16'hffff, 0, 1'b0);
    add_cmd(KIND_INSERT, 8'hff, 16'hffff, 0, 1'b0);
    add_cmd(KIND_INSERT, 8'h00, 16'h0000, 0, 1'b0);
    add_cmd(KIND_INSERT, 8'h00, 16'h1234, 2, 1'b0);
    add_cmd(KIND_INSERT, 8'hff, 16'h0001, 0, 1'b0);
    add_cmd(KIND_INSERT, 8'h80, 16'ha5a5, 1, 1'b0);
    add_cmd(KIND_INSERT, 8'h80, 16'h5a5a, 0, 1'b0);
    add_cmd(KIND_INSERT, 8'h7f, 16'h8000, 0, 1'b0);
    repeat (7) add_cmd(KIND_REMOVE, 8'h00, 16'h0000, 0, 1'b0);
    add_cmd(KIND_REMOVE, 8'h55, 16'haaaa, 3, 1'b0);
    add_cmd(KIND_REMOVE, 8'h00, 16'h0000, 0, 1'b1);

    // Fill past full, drain past empty, then biased random phases
    phase = 0;
    while (queued_items < TARGET_ITEMS) begin
      if (phase == 0) begin
        ins_pct   = 100;
        phase_len = 20;
      end else if (phase == 1) begin
        ins_pct   = 0;
        phase_len = 20;
      end else begin
        case ($urandom_range(0, 2))
          0:       ins_pct = 85;
          1:       ins_pct = 15;
          default: ins_pct = 50;
        endcase
        phase_len = $urandom_range(10, 40);
      end
      quiet    = ($urandom_range(0, 3) == 0);
      tie_keys = ($urandom_range(0, 2) == 0);
      for (n = 0; n < phase_len; n++) begin
        key = tie_keys ? 8'($urandom_range(0, 3)) : 8'($urandom);
        add_cmd(($urandom_range(1, 100) <= ins_pct) ? KIND_INSERT : KIND_REMOVE,
                key, 16'($urandom), quiet ? 0 : $urandom_range(0, 8), n == 0);
      end
      phase++;
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (cmd_backlog.size() != 0 || start || status_due.size() != 0);
    repeat (4) @(negedge clk);

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_TICKS * 2 * CLK_HALF);
    $display("%0t: timeout", $time);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
